// ----- src/wst_pkg.sv -----
// Package for the wheel speed tachometer: widths, register indexes,
// payload structs and controller/datapath command types.
// No dependencies; imported by every module of the block.
package wst_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CIRC_W     = 12;
	localparam int TMO_W      = 16;
	localparam int SPEED_W    = 22;
	localparam int PULSE_W    = 16;
	localparam int MS_W       = 10;
	localparam int NUM_W      = CIRC_W + MS_W;
	localparam int CMP_W      = (COUNT_BITS > TMO_W) ? COUNT_BITS : TMO_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [MS_W-1:0]   MS_PER_S   = MS_W'(1000);
	localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(2074);
	localparam logic [TMO_W-1:0]  TMO_RESET  = TMO_W'(2000);

	localparam logic [CFG_IDX_W-1:0] REG_CIRC    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);

	typedef struct packed {
		logic tick;
		logic pulse;
	} wst_in_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_mm_per_s;
		logic               beep;
		logic [PULSE_W-1:0] pulse_total;
	} wst_out_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic div_last;
		logic load_out;
	} wst_cmd_t;

	typedef struct packed {
		logic div_needed;
	} wst_sts_t;

endpackage

// ----- src/wst_dp.sv -----
// Datapath of the wheel speed tachometer: configuration registers, counters,
// restoring divider and output register.
// Depends on wst_pkg; sequenced by wst_ctrl.
module wst_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wst_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wst_pkg::wst_in_t               in_data,
	input  wst_pkg::wst_cmd_t              cmd,
	output wst_pkg::wst_sts_t              sts,
	output wst_pkg::wst_out_t              out_data
);
	import wst_pkg::*;

	logic [CIRC_W-1:0]     circ_q;
	logic [TMO_W-1:0]      timeout_q;
	logic [COUNT_BITS-1:0] elapsed_q;
	logic [SPEED_W-1:0]    speed_q;
	logic [PULSE_W-1:0]    pulse_q;
	logic                  beep_q;

	logic [NUM_W-1:0]      quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;
	wst_out_t              out_q;

	logic [COUNT_BITS-1:0] elapsed_next;
	logic                  tmo_hit;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;
	logic [COUNT_BITS-1:0] rem_next;
	logic [NUM_W-1:0]      quo_next;

	always_comb begin
		elapsed_next = elapsed_q;
		// saturate at all ones
		if (in_data.tick && (elapsed_q != '1)) begin
			elapsed_next = elapsed_q + COUNT_BITS'(1);
		end
		tmo_hit = CMP_W'(elapsed_next) > CMP_W'(timeout_q);
		sts.div_needed = in_data.pulse && (elapsed_next != '0);

		trial    = {rem_q, quo_q[NUM_W-1]};
		diff     = trial - {1'b0, div_q};
		ge       = trial >= {1'b0, div_q};
		rem_next = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		quo_next = {quo_q[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q    <= CIRC_RESET;
			timeout_q <= TMO_RESET;
			elapsed_q <= '0;
			speed_q   <= '0;
			pulse_q   <= '0;
			beep_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CIRC:    circ_q    <= cfg_data[CIRC_W-1:0];
					REG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
					default:     ;
				endcase
			end
			if (cmd.accept) begin
				if (in_data.pulse) begin
					elapsed_q <= '0;
					pulse_q   <= pulse_q + PULSE_W'(1);
					beep_q    <= 1'b1;
					if (!sts.div_needed) begin
						speed_q <= '0;
					end
				end else begin
					elapsed_q <= elapsed_next;
					beep_q    <= 1'b0;
					if (tmo_hit) begin
						speed_q <= '0;
					end
				end
			end
			if (cmd.div_last) begin
				speed_q <= quo_next[SPEED_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			quo_q <= NUM_W'(circ_q) * NUM_W'(MS_PER_S);
			rem_q <= '0;
			div_q <= elapsed_next;
		end else if (cmd.div_step) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
		if (cmd.load_out) begin
			out_q.speed_mm_per_s <= speed_q;
			out_q.beep           <= beep_q;
			out_q.pulse_total    <= pulse_q;
		end
	end

	assign out_data = out_q;

endmodule

// ----- src/wst_ctrl.sv -----
// Controller of the wheel speed tachometer: input/output handshakes and
// sequencing of the divider steps. Depends on wst_pkg; drives wst_dp.
module wst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  wst_pkg::wst_sts_t sts,
	output wst_pkg::wst_cmd_t cmd
);
	import wst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WRITE
	} state_t;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 slot_free;

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		slot_free    = !out_valid_q || out_ready;
		cmd.accept   = in_valid && in_ready;
		cmd.div_step = (state_q == S_DIV);
		cmd.div_last = (state_q == S_DIV) && (cnt_q == DIV_LAST);
		cmd.load_out = (state_q == S_WRITE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop valid once taken, unless a new result replaces it at this edge
			if (out_valid_q && out_ready && !cmd.load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						cnt_q   <= '0;
						state_q <= sts.div_needed ? S_DIV : S_WRITE;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cmd.div_last) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/wheel_speed_tachometer_top.sv -----
// Top level of the wheel speed tachometer: ports, configuration channel
// and wiring of controller and datapath. Depends on wst_pkg, wst_ctrl, wst_dp.
// Usage:
//   Input channel (in_valid/in_ready/in_data): one transfer per item; tick
//   says a millisecond passed, pulse says a wheel sensor edge arrived.
//   Output channel (out_valid/out_ready/out_data): exactly one transfer per
//   input item, carrying speed in mm/s, the beep flag and the pulse total.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//   always high; index 0 writes the circumference, index 1 the timeout, any
//   other index is ignored. Write only while the block is idle.
// Timing:
//   An item with a pulse and a nonzero count runs a restoring divider that
//   retires one quotient bit per cycle; its result is then loaded into the
//   output register once that register is free, and so is the result of any
//   other item. The next item is taken as soon as the result is loaded, so
//   a result may wait while the next one computes.
// Reset: arst_n clears the counters and speed and restores the register defaults.
// Stall: with a result still held, a finished item waits until out_ready frees
//   the output register; no input is taken meanwhile.
module wheel_speed_tachometer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wst_pkg::wst_in_t               in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output wst_pkg::wst_out_t              out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wst_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wst_pkg::*;

	wst_cmd_t cmd;
	wst_sts_t sts;

	// configuration registers take a write in any cycle
	assign cfg_ready = 1'b1;

	wst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for wheel_speed_tachometer_top: directed table, random phases, then a long period.
// An in-bench speed predictor, or a typed result, gives the reading each output transfer is checked against.
// Depends on wst_pkg and the block's RTL.
module tb_top;
	import wst_pkg::*;

	// Bench timing and sizes
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS    = 205;
	localparam int PHASE_COUNT    = 8;
	localparam int LONG_TICKS     = 200;
	localparam int MS_PER_SEC     = 1000;

	// Indexes the block has no register behind; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// One row of the directed table: either an item or a register write.
	// Rows with fixed set carry a hand-typed result that replaces the prediction.
	typedef struct packed {
		row_kind_t              kind;
		logic                   tick;
		logic                   pulse;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   fixed;
		wst_out_t               want;
	} plan_row_t;

	typedef struct packed {
		logic     fixed;
		wst_out_t val;
	} reading_pin_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	wst_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	wst_out_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state and its copy of the registers
	logic [COUNT_BITS-1:0] ms_since_pulse;
	logic [SPEED_W-1:0]    speed_now;
	logic [PULSE_W-1:0]    pulses_seen;
	logic [CIRC_W-1:0]     circ_mm;
	logic [TMO_W-1:0]      timeout_ms;

	// Readings still owed by the block, oldest first
	wst_out_t     pending_readings[$];
	// Typed results queued by the sender, one per offered item
	reading_pin_t typed_readings[$];
	plan_row_t    plan[$];

	int mismatches  = 0;
	int quiet_cycles = 0;

	// Handshake knobs shared between sender and receiver
	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;
	bit rx_hold_req = 1'b0;

	wheel_speed_tachometer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void tacho_reset();
		ms_since_pulse = '0;
		speed_now      = '0;
		pulses_seen    = '0;
		circ_mm        = CIRC_W'(2074);
		timeout_ms     = TMO_W'(2000);
	endfunction

	// Advance the tachometer by one item and return the reading it yields.
	// The tick is counted before the pulse is looked at, so a tick and a
	// pulse together measure a period that includes this millisecond.
	function automatic wst_out_t tacho_advance(input logic tick, input logic pulse);
		wst_out_t r;
		if (tick && ms_since_pulse != '1) begin
			ms_since_pulse = ms_since_pulse + 1'b1;
		end
		if (pulse) begin
			if (ms_since_pulse != '0) begin
				speed_now = SPEED_W'(64'(circ_mm) * 64'(MS_PER_SEC) / 64'(ms_since_pulse));
			end else begin
				speed_now = '0;
			end
			ms_since_pulse = '0;
			pulses_seen    = pulses_seen + 1'b1;
		end else if (64'(ms_since_pulse) > 64'(timeout_ms)) begin
			// wheel stopped: no pulse for longer than the timeout
			speed_now = '0;
		end
		r.speed_mm_per_s = speed_now;
		r.beep           = pulse;
		r.pulse_total    = pulses_seen;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: every transfer is seen here, at the edge that completes it
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		wst_out_t     want;
		reading_pin_t pin;
		if (arst_n) begin
			// check the output first so an item taken at this edge can never
			// be matched against a result that left at the same edge
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					$display("%0t: reading with none owed: speed %0d beep %0d total %0d",
						$time, out_data.speed_mm_per_s, out_data.beep, out_data.pulse_total);
					mismatches++;
				end else begin
					want = pending_readings.pop_front();
					if (out_data.speed_mm_per_s !== want.speed_mm_per_s) begin
						$display("%0t: speed_mm_per_s expected %0d got %0d",
							$time, want.speed_mm_per_s, out_data.speed_mm_per_s);
						mismatches++;
					end
					if (out_data.beep !== want.beep) begin
						$display("%0t: beep expected %0d got %0d",
							$time, want.beep, out_data.beep);
						mismatches++;
					end
					if (out_data.pulse_total !== want.pulse_total) begin
						$display("%0t: pulse_total expected %0d got %0d",
							$time, want.pulse_total, out_data.pulse_total);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				pin  = typed_readings.pop_front();
				want = tacho_advance(in_data.tick, in_data.pulse);
				if (pin.fixed) begin
					want = pin.val;
				end
				pending_readings.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CIRC: begin
						circ_mm = cfg_data[CIRC_W-1:0];
					end
					REG_TIMEOUT: begin
						timeout_ms = cfg_data[TMO_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// Watchdog: end the run if no transfer of any kind happens for too long
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("tb_top: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Idle length: mostly none, often a few cycles, now and then a long gap
	function automatic int next_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	// Number of ticks between two pulses: mostly short, some long enough to time out
	function automatic int train_len();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6) begin
			return $urandom_range(0, 6);
		end else if (roll < 9) begin
			return $urandom_range(7, 40);
		end
		return $urandom_range(41, 150);
	endfunction

	function automatic plan_row_t put(input logic tick, input logic pulse);
		return '{ROW_ITEM, tick, pulse, '0, '0, 1'b0, '0};
	endfunction

	function automatic plan_row_t put_typed(input logic tick, input logic pulse,
			input int speed, input logic beep, input int total);
		wst_out_t w;
		w.speed_mm_per_s = SPEED_W'(speed);
		w.beep           = beep;
		w.pulse_total    = PULSE_W'(total);
		return '{ROW_ITEM, tick, pulse, '0, '0, 1'b1, w};
	endfunction

	function automatic plan_row_t reg_wr(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		return '{ROW_REG, 1'b0, 1'b0, idx, data, 1'b0, '0};
	endfunction

	// Offer one item and hold it until the block takes the transfer.
	// Valid stays high afterwards so the next item can follow back to back.
	task automatic offer(input logic tick, input logic pulse,
			input logic fixed = 1'b0, input wst_out_t val = '0);
		int gap;
		gap = tx_steady ? 0 : next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_readings.push_back('{fixed, val});
		in_valid      <= 1'b1;
		in_data.tick  <= tick;
		in_data.pulse <= pulse;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every owed reading has been taken.
	// The first edge lets the monitor log an item taken at the current edge.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Write one register; the extra edge keeps two writes from
	// lowering and raising cfg_valid in the same step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One random phase: set both registers while idle, then mostly
	// tick trains closed by a pulse, with loose random items mixed in
	task automatic run_phase(input logic [CFG_DATA_W-1:0] circ_word,
			input logic [CFG_DATA_W-1:0] tmo_word, input int budget, input bit hold_rx);
		int sent;
		int roll;
		int ticks;
		sent = 0;
		settle();
		write_reg(REG_CIRC, circ_word);
		write_reg(REG_TIMEOUT, tmo_word);
		if ($urandom_range(0, 2) == 0) begin
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
		end
		if (hold_rx) begin
			rx_hold_req = 1'b1;
		end
		while (sent < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end else if (roll < 14 && !tx_steady) begin
				settle();
			end else begin
				ticks = train_len();
				for (int j = 0; j < ticks; j++) begin
					if ($urandom_range(0, 4) == 0) begin
						offer(1'b0, 1'b0);
						sent++;
					end
					offer(1'b1, 1'b0);
					sent++;
				end
				offer(1'($urandom_range(0, 1)), 1'b1);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random ready pattern, steady stretches and, in two phases, a long hold-off
	// ------------------------------------------------------------------

	initial begin
		int gap;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			if (rx_hold_req) begin
				// hold off long enough for the block to fill and stall its input
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				gap = next_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender and run control
	// ------------------------------------------------------------------

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		tacho_reset();

		// Directed table. Typed results are the ones plain from the defaults
		// and the extremes; the rest go through the predictor.
		plan = '{
			put_typed(1'b0, 1'b0, 0, 1'b0, 0),          // straight out of reset
			put_typed(1'b0, 1'b1, 0, 1'b1, 1),          // pulse with nothing counted
			put_typed(1'b1, 1'b0, 0, 1'b0, 1),
			put_typed(1'b1, 1'b1, 1037000, 1'b1, 2),    // tick and pulse together: 2 ms
			reg_wr(REG_CIRC, 16'hFFFF),                 // upper bits dropped: 4095 mm
			put_typed(1'b1, 1'b1, 4095000, 1'b1, 3),    // fastest wheel
			put(1'b1, 1'b0),
			reg_wr(REG_TIMEOUT, 16'h0000),
			put_typed(1'b0, 1'b0, 0, 1'b0, 3),          // zero timeout, count of one
			put(1'b1, 1'b1),
			reg_wr(REG_SPARE_A, 16'hFFFF),              // no register there
			reg_wr(REG_SPARE_B, 16'h0000),
			put_typed(1'b1, 1'b1, 4095000, 1'b1, 5),    // spare writes left no trace
			reg_wr(REG_CIRC, 16'h0000),
			put(1'b1, 1'b0),
			put_typed(1'b1, 1'b1, 0, 1'b1, 6),          // zero circumference
			reg_wr(REG_CIRC, 16'h0001),
			reg_wr(REG_TIMEOUT, 16'hFFFF),
			put(1'b1, 1'b0),
			put(1'b1, 1'b0),
			put(1'b1, 1'b0),
			put(1'b1, 1'b1),
			put_typed(1'b0, 1'b1, 0, 1'b1, 8)           // back-to-back pulses
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				offer(plan[i].tick, plan[i].pulse, plan[i].fixed, plan[i].want);
			end
		end

		// Random phases over several register settings, extremes first.
		// Phase 1 runs the sender flat out against a long receiver hold-off;
		// phase 4 has no idling on either side.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			tx_steady = (p == 1) || (p == 4);
			rx_steady = (p == 4);
			case (p)
				0: run_phase(16'd2074, 16'd2000, PHASE_ITEMS, 1'b0);
				1: run_phase(16'h0FFF, 16'h0000, PHASE_ITEMS, 1'b1);
				2: run_phase(16'h0001, 16'h0001, PHASE_ITEMS, 1'b0);
				3: run_phase(16'hF000, 16'hFFFF, PHASE_ITEMS, 1'b0);
				default: run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 60)),
					PHASE_ITEMS, p == 6);
			endcase
		end

		// Run a long period under the longest timeout, so the held speed
		// must survive, then measure that period
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		settle();
		write_reg(REG_CIRC, 16'd2074);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		offer(1'b1, 1'b1);
		for (int n = 0; n < LONG_TICKS; n++) begin
			offer(1'b1, 1'b0);
		end
		offer(1'b0, 1'b1);
		offer(1'b1, 1'b0);
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
